// ----- hdl/gh_pkg.sv -----
// GHASH accumulator package: action codes, register indexes, block type
// and bit/byte helper functions shared by the multiplier and the top level.
// No dependencies.
package gh_pkg;

  // Width of one GCM block and of the byte counters
  localparam int unsigned BlockBits  = 128;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CntW       = 61;

  typedef logic [BlockBits-1:0] block_t;
  typedef logic [CntW-1:0]      cnt_t;

  // Request action codes, carried on tuser
  typedef enum logic [1:0] {
    ACT_AAD    = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // Configuration register indexes
  localparam logic [0:0] REG_KEY_HI = 1'b0;
  localparam logic [0:0] REG_KEY_LO = 1'b1;

  // Saturation limit for the byte count
  localparam logic [4:0] FULL_COUNT = 5'(BlockBytes);

  // Bit reversal: GCM bit 0 (MSB of byte 0) becomes coefficient x^0
  function automatic block_t bit_rev(block_t v);
    block_t r;
    for (int i = 0; i < BlockBits; i++) begin
      r[i] = v[BlockBits-1-i];
    end
    return r;
  endfunction

  // Keep the first n bytes of a big-endian block; n above 16 keeps all
  function automatic block_t byte_mask(logic [4:0] n);
    block_t m;
    for (int i = 0; i < BlockBytes; i++) begin
      m[BlockBits-1-8*i -: 8] = (5'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- hdl/gh_gfmul.sv -----
// GF(2^128) multiplier in GCM bit order: carryless 128x128 product
// followed by reduction modulo x^128 + x^7 + x^2 + x + 1. Uses gh_pkg.
module gh_gfmul
  import gh_pkg::*;
(
  input  block_t x_i,
  input  block_t h_i,
  output block_t z_o
);

  block_t       a;
  block_t       b;
  logic [254:0] prod;
  logic [126:0] prod_hi;
  logic [133:0] fold;
  logic [5:0]   spill;
  block_t       red;

  // Polynomial view: bit i is the coefficient of x^i
  assign a = bit_rev(x_i);
  assign b = bit_rev(h_i);

  // Carryless product, one shifted partial product per bit of a
  always_comb begin
    prod = '0;
    for (int i = 0; i < BlockBits; i++) begin
      if (a[i]) begin
        prod = prod ^ ({127'b0, b} << i);
      end
    end
  end

  // First fold of the upper half, x^128 = x^7 + x^2 + x + 1
  assign prod_hi = prod[254:128];
  assign fold = {6'b0, prod[127:0]} ^ {7'b0, prod_hi} ^ {6'b0, prod_hi, 1'b0}
              ^ {5'b0, prod_hi, 2'b0} ^ {prod_hi, 7'b0};

  // Second fold of the few bits that spill past x^127
  assign spill = fold[133:128];
  assign red = fold[127:0] ^ {122'b0, spill} ^ {121'b0, spill, 1'b0}
             ^ {120'b0, spill, 2'b0} ^ {115'b0, spill, 7'b0};

  assign z_o = bit_rev(red);

endmodule

// ----- hdl/ghash_accumulator.sv -----
// GHASH accumulator top level: input register, GF(2^128) multiply-accumulate,
// result register. Uses gh_pkg and gh_gfmul.
// Path: input register to result register; the input stage holds while the
// result register is full and its result is not taken.
// Throughput: one request per cycle while the result stream is not stalled;
// the accumulator feedback through the combinational gh_gfmul multiplier sets that figure.
// Reset (asynchronous, active low) clears the hash key, the accumulator,
// both byte counters and all valid flags.
module ghash_accumulator
  import gh_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration write port
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_addr_i,
  input  logic [63:0]   cfg_data_i,
  // request stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,  // byte_count[4:0], block_hi[68:5], block_lo[132:69]
  input  logic [1:0]    s_axis_tuser,  // action[1:0]
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata   // hash_hi[63:0], hash_lo[127:64]
);

  // Hash subkey
  block_t  key_q;

  // Input register
  logic    in_vld_q;
  action_e in_act_q;
  logic [4:0] in_cnt_q;
  block_t  in_blk_q;

  // Running state
  block_t  acc_q, acc_d;
  cnt_t    aad_q, aad_d;
  cnt_t    txt_q, txt_d;

  // Result register
  logic    out_vld_q;
  block_t  out_hash_q;

  logic    s_accept;
  logic    advance;
  logic [4:0] add_cnt;
  block_t  mul_blk;
  block_t  mul_z;

  // Handshakes: input stage moves on when the result register is free
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_KEY_HI: key_q[127:64] <= cfg_data_i;
        REG_KEY_LO: key_q[63:0]   <= cfg_data_i;
        default:    key_q         <= key_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_act_q <= action_e'(s_axis_tuser);
      in_cnt_q <= s_axis_tdata[4:0];
      in_blk_q <= {s_axis_tdata[68:5], s_axis_tdata[132:69]};
    end
  end

  // Byte count saturates at a full block
  assign add_cnt = (in_cnt_q > FULL_COUNT) ? FULL_COUNT : in_cnt_q;

  // Multiplier operand: masked data block, or the bit-length block on finish
  always_comb begin
    if (in_act_q == ACT_FINISH) begin
      mul_blk = {aad_q, 3'b0, txt_q, 3'b0};
    end else begin
      mul_blk = in_blk_q & byte_mask(in_cnt_q);
    end
  end

  gh_gfmul u_gfmul (
    .x_i (acc_q ^ mul_blk),
    .h_i (key_q),
    .z_o (mul_z)
  );

  // Next state per action
  always_comb begin
    acc_d = acc_q;
    aad_d = aad_q;
    txt_d = txt_q;
    unique case (in_act_q)
      ACT_AAD: begin
        if (in_cnt_q != 5'd0) begin
          acc_d = mul_z;
          aad_d = aad_q + cnt_t'(add_cnt);
        end
      end
      ACT_TEXT: begin
        if (in_cnt_q != 5'd0) begin
          acc_d = mul_z;
          txt_d = txt_q + cnt_t'(add_cnt);
        end
      end
      ACT_FINISH: begin
        acc_d = mul_z ^ in_blk_q;
      end
      ACT_CLEAR: begin
        acc_d = '0;
        aad_d = '0;
        txt_d = '0;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      aad_q <= '0;
      txt_q <= '0;
    end else if (advance) begin
      acc_q <= acc_d;
      aad_q <= aad_d;
      txt_q <= txt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hash_q <= acc_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_hash_q[63:0], out_hash_q[127:64]};

endmodule
